// ===== src/lpq_pkg.sv =====
package lpq_pkg;

    localparam int MAX_LINE = 4096;

    localparam int COUNT_W = 13;
    localparam int LEVEL_W = 10;
    localparam int COMP_W  = 8;
    localparam int PROD_W  = 23;

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_LINE < 8191) ? COUNT_W'(MAX_LINE) : COUNT_W'(8191);

    localparam logic [LEVEL_W-1:0] LEVEL_MIN_INIT = 10'd800;
    localparam logic [PROD_W-1:0]  PERMILLE_SCALE = 23'd1000;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTRAST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_PERMILLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_WHITE_RUNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WHITE_RUNS   = 3'd5;

    localparam int CFG_DATA_W = 10;

    localparam logic [9:0] RST_WHITE_LEVEL     = 10'd650;
    localparam logic [9:0] RST_DARK_LIMIT      = 10'd382;
    localparam logic [9:0] RST_MIN_CONTRAST    = 10'd40;
    localparam logic [9:0] RST_BRIGHT_PERMILLE = 10'd100;
    localparam logic       RST_CHECK_RUNS      = 1'b0;
    localparam logic [3:0] RST_MIN_WHITE_RUNS  = 4'd3;

    typedef enum logic [1:0] {
        VERDICT_OK         = 2'd0,
        VERDICT_FEW_LIGHTS = 2'd1,
        VERDICT_LOW_CONTR  = 2'd2,
        VERDICT_WHITE_RUNS = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              last_in_line;
    } t_pixel;

    typedef struct packed {
        logic              line_ok;
        logic [1:0]        verdict_code;
        logic [COUNT_W-1:0] light_count;
        logic [COUNT_W-1:0] dark_count;
        logic [COUNT_W-1:0] white_count;
        logic [COUNT_W-1:0] white_runs;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
    } t_result;

    typedef struct packed {
        logic [9:0] white_level;
        logic [9:0] dark_limit;
        logic [9:0] min_contrast;
        logic [9:0] bright_permille;
        logic       check_white_runs;
        logic [3:0] min_white_runs;
    } t_cfg;

    // per-line totals handed from the accumulator to the verdict logic
    typedef struct packed {
        logic [COUNT_W-1:0] pixel_count;
        logic [COUNT_W-1:0] light_count;
        logic [COUNT_W-1:0] dark_count;
        logic [COUNT_W-1:0] white_count;
        logic [COUNT_W-1:0] white_runs;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
    } t_line_stats;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c < COUNT_CAP) ? c + 1'b1 : c;
    endfunction

endpackage

// ===== src/lpq_cfg_regs.sv =====
module lpq_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lpq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lpq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output lpq_pkg::t_cfg                       o_cfg
);

    lpq_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_level      <= lpq_pkg::RST_WHITE_LEVEL;
            r_cfg.dark_limit       <= lpq_pkg::RST_DARK_LIMIT;
            r_cfg.min_contrast     <= lpq_pkg::RST_MIN_CONTRAST;
            r_cfg.bright_permille  <= lpq_pkg::RST_BRIGHT_PERMILLE;
            r_cfg.check_white_runs <= lpq_pkg::RST_CHECK_RUNS;
            r_cfg.min_white_runs   <= lpq_pkg::RST_MIN_WHITE_RUNS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lpq_pkg::CFG_WHITE_LEVEL:      r_cfg.white_level      <= i_cfg_data;
                lpq_pkg::CFG_DARK_LIMIT:       r_cfg.dark_limit       <= i_cfg_data;
                lpq_pkg::CFG_MIN_CONTRAST:     r_cfg.min_contrast     <= i_cfg_data;
                lpq_pkg::CFG_BRIGHT_PERMILLE:  r_cfg.bright_permille  <= i_cfg_data;
                lpq_pkg::CFG_CHECK_WHITE_RUNS: r_cfg.check_white_runs <= i_cfg_data[0];
                lpq_pkg::CFG_MIN_WHITE_RUNS:   r_cfg.min_white_runs   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/lpq_accum.sv =====
module lpq_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpq_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lpq_pkg::t_pixel       i_in_data,
    output logic                  o_snap_valid,
    input  logic                  i_snap_ready,
    output lpq_pkg::t_line_stats  o_snap
);

    logic                 r_pix_vld;
    lpq_pkg::t_pixel      r_pix;
    lpq_pkg::t_line_stats r_acc;
    logic                 r_in_run;
    logic                 r_snap_vld;
    lpq_pkg::t_line_stats r_snap;

    lpq_pkg::t_line_stats n_acc;
    logic                 n_in_run;

    logic [lpq_pkg::LEVEL_W-1:0] level;
    logic is_dark;
    logic is_white;
    logic snap_free;
    logic consume;
    logic line_end;

    assign level = lpq_pkg::LEVEL_W'(r_pix.red) + lpq_pkg::LEVEL_W'(r_pix.green)
                 + lpq_pkg::LEVEL_W'(r_pix.blue);
    assign is_dark  = (level <= i_cfg.dark_limit);
    assign is_white = !is_dark && (level >= i_cfg.white_level);

    // a non-last pixel never needs room downstream
    assign snap_free  = !r_snap_vld || i_snap_ready;
    assign consume    = r_pix_vld && (!r_pix.last_in_line || snap_free);
    assign line_end   = consume && r_pix.last_in_line;
    assign o_in_ready = !r_pix_vld || consume;

    assign o_snap_valid = r_snap_vld;
    assign o_snap       = r_snap;

    always_comb begin
        n_acc             = r_acc;
        n_in_run          = r_in_run;
        n_acc.pixel_count = lpq_pkg::sat_inc(r_acc.pixel_count);
        if (is_dark) begin
            n_acc.dark_count = lpq_pkg::sat_inc(r_acc.dark_count);
        end else begin
            n_acc.light_count = lpq_pkg::sat_inc(r_acc.light_count);
            if (is_white) begin
                n_acc.white_count = lpq_pkg::sat_inc(r_acc.white_count);
                if (!r_in_run) begin
                    n_in_run         = 1'b1;
                    n_acc.white_runs = lpq_pkg::sat_inc(r_acc.white_runs);
                end
            end else begin
                n_in_run = 1'b0;
            end
        end
        if (level < r_acc.min_level) begin
            n_acc.min_level = level;
        end
        if (level > r_acc.max_level) begin
            n_acc.max_level = level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_pix_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pix <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || line_end) begin
            r_acc.pixel_count <= '0;
            r_acc.light_count <= '0;
            r_acc.dark_count  <= '0;
            r_acc.white_count <= '0;
            r_acc.white_runs  <= '0;
            r_acc.min_level   <= lpq_pkg::LEVEL_MIN_INIT;
            r_acc.max_level   <= '0;
            r_in_run          <= 1'b0;
        end else if (consume) begin
            r_acc    <= n_acc;
            r_in_run <= n_in_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (snap_free) begin
            r_snap_vld <= line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_end) begin
            r_snap <= n_acc;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_end |=> (r_acc.pixel_count == '0) && !r_in_run)
        else $error("line state not cleared after last pixel");

    a_light_dark_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc.pixel_count < lpq_pkg::COUNT_CAP) |->
        ({1'b0, r_acc.light_count} + {1'b0, r_acc.dark_count}
            == {1'b0, r_acc.pixel_count}))
        else $error("light and dark counts do not add up to pixel count");

    a_open_run_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_acc.white_runs != '0) && (r_acc.white_count != '0))
        else $error("open white run without a counted run");

    a_snap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_vld |-> (r_snap.min_level <= r_snap.max_level)
                       && (r_snap.white_count <= r_snap.light_count))
        else $error("line totals inconsistent");
`endif

endmodule

// ===== src/lpq_verdict.sv =====
module lpq_verdict (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpq_pkg::t_cfg         i_cfg,
    input  logic                  i_snap_valid,
    output logic                  o_snap_ready,
    input  lpq_pkg::t_line_stats  i_snap,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lpq_pkg::t_result      o_out_data
);

    logic                       r_a_vld;
    lpq_pkg::t_line_stats       r_a_stats;
    logic [lpq_pkg::PROD_W-1:0] r_a_light_prod;
    logic [lpq_pkg::PROD_W-1:0] r_a_ref_prod;
    logic                       r_a_low_contrast;
    logic                       r_a_runs_fail;

    logic             r_out_vld;
    lpq_pkg::t_result r_out;

    lpq_pkg::t_result n_out;
    lpq_pkg::t_verdict code;

    logic out_free;
    logic a_free;

    assign out_free     = !r_out_vld || i_out_ready;
    assign a_free       = !r_a_vld || out_free;
    assign o_snap_ready = a_free;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_free) begin
            r_a_vld <= i_snap_valid;
        end
    end

    // products and flags for the lights ratio, contrast and run tests
    always_ff @(posedge i_clk) begin
        if (a_free && i_snap_valid) begin
            r_a_stats      <= i_snap;
            r_a_light_prod <= lpq_pkg::PROD_W'(i_snap.light_count) * lpq_pkg::PERMILLE_SCALE;
            r_a_ref_prod   <= lpq_pkg::PROD_W'(i_cfg.bright_permille)
                            * lpq_pkg::PROD_W'(i_snap.pixel_count);
            r_a_low_contrast <= (i_snap.max_level < i_snap.min_level)
                || ((i_snap.max_level - i_snap.min_level) < i_cfg.min_contrast);
            r_a_runs_fail <= i_cfg.check_white_runs && (i_snap.white_runs != '0)
                && (i_snap.white_runs < lpq_pkg::COUNT_W'(i_cfg.min_white_runs));
        end
    end

    always_comb begin
        if (r_a_light_prod <= r_a_ref_prod) begin
            code = lpq_pkg::VERDICT_FEW_LIGHTS;
        end else if (r_a_low_contrast) begin
            code = lpq_pkg::VERDICT_LOW_CONTR;
        end else if (r_a_runs_fail) begin
            code = lpq_pkg::VERDICT_WHITE_RUNS;
        end else begin
            code = lpq_pkg::VERDICT_OK;
        end
        n_out.line_ok      = (code == lpq_pkg::VERDICT_OK);
        n_out.verdict_code = code;
        n_out.light_count  = r_a_stats.light_count;
        n_out.dark_count   = r_a_stats.dark_count;
        n_out.white_count  = r_a_stats.white_count;
        n_out.white_runs   = r_a_stats.white_runs;
        n_out.min_level    = r_a_stats.min_level;
        n_out.max_level    = r_a_stats.max_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_a_vld) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.line_ok
            == (r_out.verdict_code == lpq_pkg::VERDICT_OK)))
        else $error("line_ok disagrees with verdict code");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> r_out_vld && $stable(r_out))
        else $error("stalled result changed");
`endif

endmodule

// ===== src/line_profile_qualifier.sv =====
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data  (t_pixel)
// out      output     o_out_valid / i_out_ready  o_out_data (t_result)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one pixel per cycle while no last pixel waits for the snapshot; the per-pixel
// update of the line counters is a single add, compare and saturating increment
// between the input and counter registers; after its last pixel transfer a
// line's verdict passes the counter snapshot, product stage and result register
// synchronous active-low reset clears counters and valids; no clearing pass
// a held result stalls input only once a later last pixel needs the snapshot
module line_profile_qualifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lpq_pkg::t_pixel                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lpq_pkg::t_result                  o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lpq_pkg::t_cfg        cfg;
    lpq_pkg::t_line_stats snap;
    logic                 snap_valid;
    logic                 snap_ready;

    lpq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpq_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    lpq_verdict u_verdict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
